@@ hw/rtl/spow_pkg.sv @@
// Package for the SHA-256 proof-of-work search unit: widths, round constants,
// initial hash values and the SHA-256 sigma functions. No dependencies.
`default_nettype none
package spow_pkg;
   localparam int NAME_BYTES_DEF = 64;
   localparam int ZP_W = 4;
   localparam int WORD_W = 64;
   localparam int DIGEST_BYTES = 32;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
         32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
         32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
         32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
         32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
         32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      round_k = k[t];
   endfunction

   function automatic logic [255:0] init_hash();
      init_hash = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                   32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
   endfunction

   function automatic logic [31:0] ssig0(input logic [31:0] x);
      ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction
   function automatic logic [31:0] ssig1(input logic [31:0] x);
      ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction
   function automatic logic [31:0] bsig0(input logic [31:0] x);
      bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction
   function automatic logic [31:0] bsig1(input logic [31:0] x);
      bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   // Control from the sequencer into the round unit
   typedef struct packed {
      logic        load;    // copy chaining value into working vars
      logic        run;     // perform one round
      logic [5:0]  rnd;     // round index
      logic [31:0] w_ext;   // message word for rounds 0..15
      logic        fold;    // add working vars into chaining value
      logic        chain_init;
   } spow_ctl_type;
endpackage
`default_nettype wire

@@ hw/rtl/spow_round.sv @@
// Shared SHA-256 round unit: working variables, 16-word schedule window and
// the chaining value. One round per cycle while ctl.run is set. Depends on spow_pkg.
`default_nettype none
module spow_round
   import spow_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire spow_ctl_type ctl,
   input  wire logic [255:0] chain_src,
   output logic [255:0]      chain_out,
   output logic [255:0]      fold_val
);
   logic [31:0] wv_ff [8];
   logic [31:0] wv_in [8];
   logic [31:0] sw_ff [16];
   logic [31:0] w;
   logic [31:0] t1, t2;
   logic [255:0] chain_ff, chain_in;
   logic [3:0] ti;

   assign ti = ctl.rnd[3:0];

   always_comb begin
      if (ctl.rnd < 6'd16) begin
         w = ctl.w_ext;
      end else begin
         w = sw_ff[ti] + ssig0(sw_ff[ti + 4'd1]) + sw_ff[ti + 4'd9] + ssig1(sw_ff[ti + 4'd14]);
      end
      t1 = wv_ff[7] + bsig1(wv_ff[4]) + ((wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]))
           + round_k(ctl.rnd) + w;
      t2 = bsig0(wv_ff[0]) + ((wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2])
           ^ (wv_ff[1] & wv_ff[2]));
      wv_in = wv_ff;
      if (ctl.load) begin
         for (int i = 0; i < 8; i++) wv_in[i] = chain_src[255 - 32*i -: 32];
      end else if (ctl.run) begin
         wv_in[7] = wv_ff[6];
         wv_in[6] = wv_ff[5];
         wv_in[5] = wv_ff[4];
         wv_in[4] = wv_ff[3] + t1;
         wv_in[3] = wv_ff[2];
         wv_in[2] = wv_ff[1];
         wv_in[1] = wv_ff[0];
         wv_in[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) begin
         fold_val[255 - 32*i -: 32] = chain_src[255 - 32*i -: 32] + wv_ff[i];
      end
      chain_in = chain_ff;
      if (ctl.chain_init) begin
         chain_in = init_hash();
      end else if (ctl.fold) begin
         chain_in = fold_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= init_hash();
         for (int i = 0; i < 8; i++) wv_ff[i] <= '0;
      end else begin
         chain_ff <= chain_in;
         wv_ff <= wv_in;
      end
      if (ctl.run) begin
         sw_ff[ti] <= w;
      end
   end

   assign chain_out = chain_ff;
endmodule
`default_nettype wire

@@ hw/rtl/sha256_proof_of_work_search_unit.sv @@
// SHA-256 proof-of-work search unit. Takes a header as a series of 64-bit
// little-endian words (HEADER_WORDS of them, 18 for 64-byte names), one
// transfer per cycle while req_stall is low. On the last word it hashes the
// header blocks once into a midstate, then tries nonces counting up from 0,
// appended little-endian, until the digest begins with csr_zero_prefix_bytes
// zero bytes (0 accepts anything; every setting up to 15 is compared byte for
// byte). One transfer on rsp_ gives the nonce with rsp_found set, or nonce 0
// with found clear if the space runs out.
// Rounds run one per cycle on a single shared round unit; every compression
// is a load, 64 rounds and a fold. The midstate takes one compression per
// header block and each trial one per tail block plus a digest check. The
// default size has two header blocks and one tail block.
// req_stall is high from the last header word until the search ends. While a
// result waits on rsp_ the next header's words are still taken, except the
// last one, which is held off until the result transfer.
// Depends on spow_pkg and spow_round.
`default_nettype none
module sha256_proof_of_work_search_unit
   import spow_pkg::*;
#(
   parameter int NAME_BYTES = NAME_BYTES_DEF
)(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [WORD_W-1:0] req_header_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [WORD_W-1:0]      rsp_nonce,
   output logic                   rsp_found,
   input  wire logic              csr_write,
   input  wire logic [ZP_W-1:0]   csr_zero_prefix_bytes
);
   localparam int HEADER_WORDS = (16 + 2 * NAME_BYTES + 7) / 8;
   localparam int NONCE_OFF    = HEADER_WORDS * 8;
   localparam int MSG_BYTES    = NONCE_OFF + 8;
   localparam int PAD_BYTES    = ((MSG_BYTES + 8) / 64 + 1) * 64;
   localparam int PRE_BLOCKS   = NONCE_OFF / 64;
   localparam int ALL_BLOCKS   = PAD_BYTES / 64;
   localparam int HW_W  = $clog2(HEADER_WORDS + 1);
   localparam int HI_W  = $clog2(HEADER_WORDS);
   localparam int BLK_W = $clog2(ALL_BLOCKS + 1);
   localparam logic [63:0] MSG_BITS = 64'(MSG_BYTES * 8);

   typedef enum logic [2:0] {S_LOAD, S_START, S_ROUND, S_FOLD, S_CHECK} state_type;

   state_type          state_ff;
   logic [ZP_W-1:0]    zp_ff;
   logic [63:0]        hdr_ff [HEADER_WORDS];
   logic [HW_W-1:0]    cnt_ff;
   logic [63:0]        nonce_ff;
   logic [BLK_W-1:0]   blk_ff;
   logic [5:0]         rnd_ff;
   logic               pre_ff;     // building midstate
   logic [255:0]       mid_ff, tchain_ff;
   logic [255:0]       chain_out, fold_val, chain_src;
   logic               rsp_valid_ff;
   logic [WORD_W-1:0]  rsp_nonce_ff;
   logic               rsp_found_ff;
   logic               pass;
   spow_ctl_type       ctl;

   // Byte of the padded record at a given position
   function automatic logic [7:0] rec_byte(input int unsigned p);
      logic [7:0] b;
      b = 8'h00;
      if (p < NONCE_OFF) begin
         b = hdr_ff[HI_W'(p / 8)][8*(p % 8) +: 8];
      end else if (p < MSG_BYTES) begin
         b = nonce_ff[8*((p - NONCE_OFF) % 8) +: 8];
      end else if (p == MSG_BYTES) begin
         b = 8'h80;
      end else if (p >= PAD_BYTES - 8) begin
         b = MSG_BITS[8*(PAD_BYTES - 1 - p) +: 8];
      end
      return b;
   endfunction

   logic [31:0] w_ext;
   always_comb begin
      int unsigned base;
      base = 64 * 32'(blk_ff) + 4 * 32'(rnd_ff[3:0]);
      w_ext = {rec_byte(base), rec_byte(base + 1), rec_byte(base + 2), rec_byte(base + 3)};
   end

   assign chain_src = pre_ff ? chain_out : tchain_ff;

   spow_round u_round (
      .clock(clock), .reset(reset), .ctl(ctl), .chain_src(chain_src),
      .chain_out(chain_out), .fold_val(fold_val)
   );

   always_comb begin
      ctl.load = (state_ff == S_START);
      ctl.run = (state_ff == S_ROUND);
      ctl.rnd = rnd_ff;
      ctl.w_ext = w_ext;
      ctl.fold = (state_ff == S_FOLD) && pre_ff;
      ctl.chain_init = (state_ff == S_LOAD) && req_valid && !req_stall
                       && (cnt_ff == HW_W'(HEADER_WORDS - 1));
   end

   // Leading digest bytes against the prefix
   always_comb begin
      pass = 1'b1;
      for (int i = 0; i < DIGEST_BYTES; i++) begin
         if (i < 32'(zp_ff) && tchain_ff[255 - 8*i -: 8] != 8'h00) pass = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         zp_ff <= ZP_W'(3);
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pre_ff <= 1'b0;
      end else begin
         if (csr_write) zp_ff <= csr_zero_prefix_bytes;
         // result transfer; a search only ends while no result is held
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_LOAD: begin
               if (req_valid && !req_stall) begin
                  hdr_ff[cnt_ff[HI_W-1:0]] <= req_header_word;
                  if (cnt_ff == HW_W'(HEADER_WORDS - 1)) begin
                     cnt_ff <= '0;
                     nonce_ff <= '0;
                     rnd_ff <= '0;
                     if (PRE_BLOCKS > 0) begin
                        pre_ff <= 1'b1;
                        blk_ff <= '0;
                     end else begin
                        pre_ff <= 1'b0;
                        blk_ff <= BLK_W'(PRE_BLOCKS);
                        tchain_ff <= init_hash();
                        mid_ff <= init_hash();
                     end
                     state_ff <= S_START;
                  end else begin
                     cnt_ff <= cnt_ff + HW_W'(1);
                  end
               end
            end
            S_START: begin
               rnd_ff <= '0;
               state_ff <= S_ROUND;
            end
            S_ROUND: begin
               rnd_ff <= rnd_ff + 6'd1;
               if (rnd_ff == 6'd63) state_ff <= S_FOLD;
            end
            S_FOLD: begin
               if (pre_ff) begin
                  if (blk_ff == BLK_W'(PRE_BLOCKS - 1)) begin
                     pre_ff <= 1'b0;
                     mid_ff <= fold_val;
                     tchain_ff <= fold_val;
                  end
                  blk_ff <= blk_ff + BLK_W'(1);
                  state_ff <= S_START;
               end else begin
                  tchain_ff <= fold_val;
                  if (blk_ff == BLK_W'(ALL_BLOCKS - 1)) begin
                     state_ff <= S_CHECK;
                  end else begin
                     blk_ff <= blk_ff + BLK_W'(1);
                     state_ff <= S_START;
                  end
               end
            end
            S_CHECK: begin
               if (pass || nonce_ff == '1) begin
                  rsp_nonce_ff <= pass ? nonce_ff : '0;
                  rsp_found_ff <= pass;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_LOAD;
               end else begin
                  nonce_ff <= nonce_ff + 64'd1;
                  tchain_ff <= mid_ff;
                  blk_ff <= BLK_W'(PRE_BLOCKS);
                  state_ff <= S_START;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   // last header word waits while a result is still held
   assign req_stall = (state_ff != S_LOAD)
                      || (rsp_valid_ff && (cnt_ff == HW_W'(HEADER_WORDS - 1)));
   assign rsp_valid = rsp_valid_ff;
   assign rsp_nonce = rsp_nonce_ff;
   assign rsp_found = rsp_found_ff;
endmodule
`default_nettype wire

@@ dv/sha256_proof_of_work_search_unit_test.sv @@
// Testbench for the SHA-256 proof-of-work search unit: self-checking, with its
// own SHA-256 nonce search as the predictor. Depends on spow_pkg and the unit.
`default_nettype none
module sha256_proof_of_work_search_unit_test;
   import spow_pkg::*;

   localparam int HDR_WORDS = 18;
   localparam int REC_BYTES = 192;   // 152-byte record padded to three blocks
   localparam int NONCE_AT = 144;
   localparam longint CYCLE_LIMIT = 8000000;
   localparam int LONG_HOLD = 400;

   localparam logic [31:0] RK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
   localparam logic [255:0] IV = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                                  32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   typedef struct {
      logic [WORD_W-1:0] word;
      bit                drain;   // hold this word back until no result is owed
   } header_item_type;

   typedef struct {
      logic [WORD_W-1:0] nonce;
      logic              found;
   } search_result_type;

   // Ports
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [WORD_W-1:0] req_header_word = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [WORD_W-1:0] rsp_nonce;
   logic              rsp_found;
   logic              csr_write = 1'b0;
   logic [ZP_W-1:0]   csr_zero_prefix_bytes = '0;

   // Testbench state
   header_item_type   word_queue[$];
   search_result_type nonce_expect[$];
   logic [WORD_W-1:0] hdr_buf [HDR_WORDS];
   int                hdr_fill = 0;
   logic [ZP_W-1:0]   prefix_setting = 4'd3;   // register value out of reset
   bit                quiet = 1'b0;            // no random gaps or stalls on either side
   bit                long_hold_arm = 1'b0;
   bit                long_hold_done = 1'b0;
   int                gap_left = 0;
   int                stall_left = 0;
   int                hold_left = 0;
   int                mismatches = 0;
   longint            cycles = 0;

   sha256_proof_of_work_search_unit u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_header_word       (req_header_word),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_nonce             (rsp_nonce),
      .rsp_found             (rsp_found),
      .csr_write             (csr_write),
      .csr_zero_prefix_bytes (csr_zero_prefix_bytes)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      logic [63:0] dbl;
      dbl = {x, x} >> n;
      return dbl[31:0];
   endfunction

   // One SHA-256 compression; the block is big-endian, byte 0 in the top bits.
   function automatic logic [255:0] sha_compress(input logic [255:0] chain,
                                                 input logic [511:0] blk);
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      logic [255:0] res;
      for (int i = 0; i < 8; i++) v[i] = chain[255-32*i -: 32];
      for (int t = 0; t < 64; t++) begin
         if (t < 16) begin
            w[t] = blk[511-32*t -: 32];
         end else begin
            w[t] = w[t-16] + w[t-7]
                 + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3))
                 + (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10));
         end
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[t] + w[t];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) res[255-32*i -: 32] = chain[255-32*i -: 32] + v[i];
      return res;
   endfunction

   // Nonce search over a complete header: midstate once, then the tail block
   // per trial until the digest opens with enough zero bytes or the nonces run out.
   function automatic search_result_type search_nonce(
         input logic [WORD_W-1:0] hw [HDR_WORDS], input logic [ZP_W-1:0] zbytes);
      logic [7:0]   rec [REC_BYTES];
      logic [511:0] blk;
      logic [255:0] mid, dig;
      logic [63:0]  bits;
      logic [63:0]  n;
      bit           ok;
      search_result_type r;
      bits = 64'd1216;
      for (int i = 0; i < REC_BYTES; i++) rec[i] = 8'h00;
      for (int i = 0; i < HDR_WORDS; i++)
         for (int j = 0; j < 8; j++) rec[8*i+j] = hw[i][8*j +: 8];
      rec[NONCE_AT+8] = 8'h80;
      for (int j = 0; j < 8; j++) rec[REC_BYTES-1-j] = bits[8*j +: 8];
      mid = IV;
      for (int b = 0; b < 2; b++) begin
         for (int i = 0; i < 64; i++) blk[511-8*i -: 8] = rec[64*b+i];
         mid = sha_compress(mid, blk);
      end
      n = '0;
      forever begin
         for (int j = 0; j < 8; j++) rec[NONCE_AT+j] = n[8*j +: 8];
         for (int i = 0; i < 64; i++) blk[511-8*i -: 8] = rec[128+i];
         dig = sha_compress(mid, blk);
         ok = 1'b1;
         for (int i = 0; i < zbytes && i < 32; i++)
            if (dig[255-8*i -: 8] != 8'h00) ok = 1'b0;
         if (ok) begin
            r.nonce = n;
            r.found = 1'b1;
            return r;
         end
         if (n == '1) break;
         n++;
      end
      r.nonce = '0;
      r.found = 1'b0;
      return r;
   endfunction

   // Header driver: offers queued words, a random gap after each transfer unless quiet.
   always @(posedge clock) begin
      header_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            hdr_buf[hdr_fill] = req_header_word;
            hdr_fill++;
            if (hdr_fill == HDR_WORDS) begin
               hdr_fill = 0;
               nonce_expect.push_back(search_nonce(hdr_buf, prefix_setting));
            end
         end
         if (req_valid && req_stall) begin
            // payload held while stalled
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (word_queue.size() > 0 &&
                      !(word_queue[0].drain && nonce_expect.size() != 0)) begin
            it = word_queue.pop_front();
            req_valid <= 1'b1;
            req_header_word <= it.word;
            gap_left = quiet ? 0 : $urandom_range(0, 8);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result monitor and stall generator.
   always @(posedge clock) begin
      search_result_type exp_r;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (nonce_expect.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result transfer: nonce %h found %b",
                           rsp_nonce, rsp_found);
            end else begin
               exp_r = nonce_expect.pop_front();
               if (rsp_nonce !== exp_r.nonce || rsp_found !== exp_r.found) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: nonce %h found %b, expected %h %b",
                              rsp_nonce, rsp_found, exp_r.nonce, exp_r.found);
               end
            end
            stall_left = quiet ? 0 : $urandom_range(0, 8);
         end
         if (long_hold_arm && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic wait_idle();
      while (word_queue.size() != 0 || req_valid || nonce_expect.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);   // let the unit settle before a register write
   endtask

   task automatic write_prefix(input logic [ZP_W-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_zero_prefix_bytes <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      prefix_setting = val;
   endtask

   task automatic queue_header(input int fill, input bit drain);
      header_item_type it;
      for (int i = 0; i < HDR_WORDS; i++) begin
         case (fill)
            0: it.word = '0;
            1: it.word = '1;
            2: it.word = (i % 2) ? '1 : '0;
            default: it.word = {$urandom, $urandom};
         endcase
         it.drain = drain && (i == 0);
         word_queue.push_back(it);
      end
   endtask

   // Sequence: register extremes written, then mostly prefix 0 (one trial per
   // search) and a stretch at prefix 1 (about 256 trials per search).
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait_idle();
      write_prefix(4'd15);
      write_prefix(4'd0);

      // directed headers: all clear, all set, alternating words
      quiet = 1'b1;
      queue_header(0, 1'b0);
      queue_header(1, 1'b0);
      queue_header(2, 1'b0);
      wait_idle();

      // receiver holds off while the sender keeps offering
      long_hold_arm = 1'b1;
      for (int h = 0; h < 10; h++) queue_header(3, 1'b0);
      wait_idle();
      quiet = 1'b0;
      for (int h = 0; h < 10; h++) queue_header(3, 1'b0);
      wait_idle();

      write_prefix(4'd8);
      write_prefix(4'd1);
      for (int h = 0; h < 12; h++) queue_header(3, h == 6);
      wait_idle();

      write_prefix(4'd0);
      for (int h = 0; h < 20; h++) queue_header(3, h == 10);
      wait_idle();
      quiet = 1'b1;
      for (int h = 0; h < 3; h++) queue_header(3, 1'b0);
      wait_idle();

      repeat (200) @(posedge clock);
      if (mismatches == 0 && nonce_expect.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire
